// File: sv/lzss_pkg.sv
// shared constants and codes for the lzss stream decoder
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 24;
  localparam int STAT_W       = 2;
  localparam int TOK_W        = 16;
  localparam int LEN_W        = 5;
  localparam int MIN_MATCH    = 3;

  localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'h20;
  localparam logic [TOK_W-1:0]  FLAG_SENTINEL = 16'hff00;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_TRUNC    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

endpackage

`default_nettype wire

// File: sv/lzss_in_if.sv
// compressed byte channel
`default_nettype none

interface lzss_in_if;
  logic                        valid;
  logic                        ready;
  logic [lzss_pkg::BYTE_W-1:0] in_byte;
  logic                        in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: sv/lzss_out_if.sv
// decompressed byte and status channel
`default_nettype none

interface lzss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        out_kind;
  logic [lzss_pkg::BYTE_W-1:0] out_byte;
  logic [lzss_pkg::STAT_W-1:0] end_status;
  logic [lzss_pkg::CNT_W-1:0]  out_count;
  logic                        out_last;

  modport source (output valid, output out_kind, output out_byte, output end_status,
                  output out_count, output out_last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input end_status,
                  input out_count, input out_last, output ready);
endinterface

`default_nettype wire

// File: sv/lzss_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = lzss_pkg::BYTE_W,
  parameter int DEPTH = lzss_pkg::WINDOW_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/lzss_stream_decoder.sv
// lzss stream decoder top level with 4096 byte history ring
//
// in_s carries one compressed byte per beat, in_last on the final byte of a
// stream. out_m carries decompressed data beats (out_kind 0) and, after the
// final input byte, one status beat (out_kind 1) with the total count.
// cfg_we/cfg_wdata set the expected decompressed length; write it between
// streams.
// each input beat is decoded in the cycle it is accepted. a flag byte or the
// first byte of a match is taken in idle; a literal goes via S_LIT, a match
// of 3 to 18 bytes via S_MRD and S_MCP (one ring read per cycle on the single
// read port unless stalled), a status beat via S_STAT. in_ready is high only
// while the sequencer is idle. a finished beat waits in the output register;
// while it waits and out_m.ready is low, S_LIT, S_MCP and S_STAT hold.
// the ring is never swept: a fill count (write pointer plus a wrapped flag)
// marks which entries this stream has written, others read as spaces. after
// reset and after every status beat the stream state is back to its start;
// reset also clears the expected length.
`default_nettype none

module lzss_stream_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lzss_in_if.sink                          in_s,
  lzss_out_if.source                       out_m,
  input  wire logic                        cfg_we,
  input  wire logic [lzss_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int AW  = lzss_pkg::WIN_AW;
  localparam int BW  = lzss_pkg::BYTE_W;
  localparam int CW  = lzss_pkg::CNT_W;
  localparam int SW  = lzss_pkg::STAT_W;
  localparam int TW  = lzss_pkg::TOK_W;
  localparam int LW  = lzss_pkg::LEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIT  = 3'd1;
  localparam logic [2:0] S_MRD  = 3'd2;
  localparam logic [2:0] S_MCP  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          full_r, full_nxt;
  logic [TW-1:0] tok_r, tok_nxt;
  logic [BW-1:0] low_r, low_nxt;
  logic          await2_r, await2_nxt;
  logic          awtok_r, awtok_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] err_r, err_nxt;
  logic [CW-1:0] exp_r, exp_nxt;
  logic          last_r, last_nxt;
  logic [BW-1:0] lit_r, lit_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic          fwd_r, fwd_nxt;
  logic [BW-1:0] fwdb_r, fwdb_nxt;
  logic          vld_r, vld_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic          okind_r, okind_nxt;
  logic [BW-1:0] obyte_r, obyte_nxt;
  logic [SW-1:0] ostat_r, ostat_nxt;
  logic [CW-1:0] ocount_r, ocount_nxt;
  logic          olast_r, olast_nxt;

  logic          ram_we;
  logic          ram_re;
  logic [BW-1:0] ram_rdata;
  logic [BW-1:0] ring_byte;
  logic          slot_free;
  logic          in_acc;
  logic          emit_en;
  logic [BW-1:0] emit_byte;
  logic          emit_last;
  logic [TW-1:0] tok_sh;
  logic [LW-1:0] mlen;
  logic [LW-1:0] need;
  logic          no_room;
  logic          tok_bit;
  logic          tok_used;
  logic          go_lit;
  logic          go_match;
  logic [SW-1:0] fin_stat;

  lzss_ram #(
    .WIDTH (BW),
    .DEPTH (lzss_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  assign in_s.ready       = (state_r == S_IDLE);
  assign in_acc           = in_s.valid && in_s.ready;
  assign slot_free        = !ovalid_r || out_m.ready;
  assign ring_byte        = fwd_r ? fwdb_r : (vld_r ? ram_rdata : lzss_pkg::FILL_BYTE);

  assign out_m.valid      = ovalid_r;
  assign out_m.out_kind   = okind_r;
  assign out_m.out_byte   = obyte_r;
  assign out_m.end_status = ostat_r;
  assign out_m.out_count  = ocount_r;
  assign out_m.out_last   = olast_r;

  // shared room check: count plus bytes needed against expected length
  assign tok_sh  = {1'b0, tok_r[TW-1:1]};
  assign mlen    = LW'(in_s.in_byte[7:4]) + LW'(lzss_pkg::MIN_MATCH);
  assign need    = await2_r ? mlen : LW'(1);
  assign no_room = ({1'b0, cnt_r} + (CW+1)'(need)) > {1'b0, exp_r};

  always_comb begin
    if (err_r != lzss_pkg::ST_OK) begin
      fin_stat = err_r;
    end else if (awtok_r) begin
      fin_stat = lzss_pkg::ST_TRUNC;
    end else if (cnt_r != exp_r) begin
      fin_stat = lzss_pkg::ST_MISMATCH;
    end else begin
      fin_stat = lzss_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    full_nxt   = full_r;
    tok_nxt    = tok_r;
    low_nxt    = low_r;
    await2_nxt = await2_r;
    awtok_nxt  = awtok_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    exp_nxt    = cfg_we ? cfg_wdata : exp_r;
    last_nxt   = last_r;
    lit_nxt    = lit_r;
    src_nxt    = src_r;
    rem_nxt    = rem_r;
    fwd_nxt    = fwd_r;
    fwdb_nxt   = fwdb_r;
    vld_nxt    = vld_r;
    ovalid_nxt = ovalid_r && !out_m.ready;
    okind_nxt  = okind_r;
    obyte_nxt  = obyte_r;
    ostat_nxt  = ostat_r;
    ocount_nxt = ocount_r;
    olast_nxt  = olast_r;
    ram_re     = 1'b0;
    emit_en    = 1'b0;
    emit_byte  = lit_r;
    emit_last  = 1'b0;
    tok_bit    = 1'b0;
    tok_used   = 1'b0;
    go_lit     = 1'b0;
    go_match   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_s.in_last;
          if (err_r == lzss_pkg::ST_OK) begin
            if (await2_r) begin
              await2_nxt = 1'b0;
              if (no_room) begin
                err_nxt = lzss_pkg::ST_OVERFLOW;
              end else begin
                go_match = 1'b1;
              end
            end else if (awtok_r) begin
              awtok_nxt = 1'b0;
              tok_used  = 1'b1;
              tok_bit   = tok_r[0];
            end else if (!tok_sh[8]) begin
              tok_nxt   = lzss_pkg::FLAG_SENTINEL | TW'(in_s.in_byte);
              awtok_nxt = 1'b1;
            end else begin
              tok_nxt  = tok_sh;
              tok_used = 1'b1;
              tok_bit  = tok_sh[0];
            end
            if (tok_used) begin
              if (!tok_bit) begin
                low_nxt    = in_s.in_byte;
                await2_nxt = 1'b1;
              end else if (no_room) begin
                err_nxt = lzss_pkg::ST_OVERFLOW;
              end else begin
                go_lit = 1'b1;
              end
            end
          end
          if (go_lit) begin
            lit_nxt   = in_s.in_byte;
            state_nxt = S_LIT;
          end else if (go_match) begin
            src_nxt   = {in_s.in_byte[3:0], low_r};
            rem_nxt   = mlen;
            state_nxt = S_MRD;
          end else if (in_s.in_last) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_LIT: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          emit_byte = lit_r;
          emit_last = !last_r;
          state_nxt = last_r ? S_STAT : S_IDLE;
        end
      end
      S_MRD: begin
        ram_re    = 1'b1;
        fwd_nxt   = 1'b0;
        vld_nxt   = full_r || (src_r < wp_r);
        src_nxt   = src_r + AW'(1);
        state_nxt = S_MCP;
      end
      S_MCP: begin
        if (slot_free) begin
          emit_en   = 1'b1;
          emit_byte = ring_byte;
          emit_last = (rem_r == LW'(1)) && !last_r;
          rem_nxt   = rem_r - LW'(1);
          if (rem_r != LW'(1)) begin
            // next source may be the entry written this cycle
            ram_re   = 1'b1;
            fwd_nxt  = (src_r == wp_r);
            fwdb_nxt = ring_byte;
            vld_nxt  = full_r || (src_r < wp_r);
            src_nxt  = src_r + AW'(1);
          end else begin
            state_nxt = last_r ? S_STAT : S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = lzss_pkg::KIND_STAT;
          obyte_nxt  = '0;
          ostat_nxt  = fin_stat;
          ocount_nxt = cnt_r;
          olast_nxt  = 1'b1;
          wp_nxt     = '0;
          full_nxt   = 1'b0;
          tok_nxt    = '0;
          low_nxt    = '0;
          await2_nxt = 1'b0;
          awtok_nxt  = 1'b0;
          cnt_nxt    = '0;
          err_nxt    = lzss_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_en) begin
      wp_nxt     = wp_r + AW'(1);
      full_nxt   = full_r || (wp_r == '1);
      cnt_nxt    = cnt_r + CW'(1);
      ovalid_nxt = 1'b1;
      okind_nxt  = lzss_pkg::KIND_DATA;
      obyte_nxt  = emit_byte;
      ostat_nxt  = lzss_pkg::ST_OK;
      ocount_nxt = cnt_r + CW'(1);
      olast_nxt  = emit_last;
    end
  end

  assign ram_we = emit_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      full_r   <= 1'b0;
      tok_r    <= '0;
      low_r    <= '0;
      await2_r <= 1'b0;
      awtok_r  <= 1'b0;
      cnt_r    <= '0;
      err_r    <= lzss_pkg::ST_OK;
      exp_r    <= '0;
      last_r   <= 1'b0;
      rem_r    <= '0;
      fwd_r    <= 1'b0;
      vld_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      full_r   <= full_nxt;
      tok_r    <= tok_nxt;
      low_r    <= low_nxt;
      await2_r <= await2_nxt;
      awtok_r  <= awtok_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      exp_r    <= exp_nxt;
      last_r   <= last_nxt;
      rem_r    <= rem_nxt;
      fwd_r    <= fwd_nxt;
      vld_r    <= vld_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r    <= lit_nxt;
    src_r    <= src_nxt;
    fwdb_r   <= fwdb_nxt;
    okind_r  <= okind_nxt;
    obyte_r  <= obyte_nxt;
    ostat_r  <= ostat_nxt;
    ocount_r <= ocount_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

`default_nettype wire

// File: sv/lzss_chk.sv
// port checker for the lzss stream decoder and its bind
`default_nettype none

module lzss_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_kind,
  input wire logic [lzss_pkg::STAT_W-1:0] end_status,
  input wire logic [lzss_pkg::CNT_W-1:0]  out_count,
  input wire logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_count))
    else $error("output beat changed while stalled");

  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == lzss_pkg::KIND_STAT) |-> out_last)
    else $error("status beat without last");

  a_data_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == lzss_pkg::KIND_DATA) |-> (end_status == lzss_pkg::ST_OK))
    else $error("data beat with nonzero status");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lzss_stream_decoder lzss_chk u_lzss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_m.valid),
  .out_ready  (out_m.ready),
  .out_kind   (out_m.out_kind),
  .end_status (out_m.end_status),
  .out_count  (out_m.out_count),
  .out_last   (out_m.out_last)
);

`default_nettype wire

// File: verif/lzss_stream_decoder_checker.sv
// channel monitor, byte-level decode prediction and result comparison for the lzss decoder
`default_nettype none

module lzss_stream_decoder_checker
  import lzss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  lzss_in_if                    in_w,
  lzss_out_if                   out_w,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  output int unsigned           mismatch_count,
  output int unsigned           beats_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              last;
  } out_beat_t;

  logic [BYTE_W-1:0] hist [WINDOW_DEPTH];
  logic [WIN_AW-1:0] wr_ptr;
  logic [TOK_W-1:0]  tokens;
  logic [BYTE_W-1:0] match_lo;
  logic              need_match_hi;
  logic              need_token;
  logic [CNT_W-1:0]  produced;
  logic [STAT_W-1:0] err;
  logic [CNT_W-1:0]  target_len;

  out_beat_t   decoded_q[$];
  out_beat_t   want;
  out_beat_t   got;
  int unsigned bad = 0;

  task automatic clear_stream();
    for (int i = 0; i < WINDOW_DEPTH; i++) hist[i] = FILL_BYTE;
    wr_ptr        = '0;
    tokens        = '0;
    match_lo      = '0;
    need_match_hi = 1'b0;
    need_token    = 1'b0;
    produced      = '0;
    err           = ST_OK;
  endtask

  function automatic logic [CNT_W-1:0] room();
    return (produced >= target_len) ? '0 : target_len - produced;
  endfunction

  task automatic push_beat(input logic kind, input logic [BYTE_W-1:0] data,
                           input logic [STAT_W-1:0] status, input logic [CNT_W-1:0] count);
    decoded_q.push_back('{kind: kind, data: data, status: status, count: count, last: 1'b0});
  endtask

  task automatic emit_byte(input logic [BYTE_W-1:0] b);
    hist[wr_ptr] = b;
    wr_ptr       = wr_ptr + 1'b1;
    produced     = produced + 1'b1;
    push_beat(KIND_DATA, b, ST_OK, produced);
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    int                n;
    int                len;
    int                i;
    logic [WIN_AW-1:0] src;
    logic [BYTE_W-1:0] c;
    logic [STAT_W-1:0] st;
    logic              is_token;
    out_beat_t         tail;
    n = 0;
    if (err == ST_OK) begin
      if (need_match_hi) begin
        need_match_hi = 1'b0;
        src = {b[3:0], match_lo};
        len = int'(b[7:4]) + MIN_MATCH;
        if (len > int'(room())) begin
          err = ST_OVERFLOW;
        end else begin
          for (i = 0; i < len; i++) begin
            c   = hist[src];
            src = src + 1'b1;
            emit_byte(c);
            n++;
          end
        end
      end else begin
        is_token = 1'b1;
        if (need_token) begin
          need_token = 1'b0;
        end else begin
          tokens = tokens >> 1;
          if (!tokens[8]) begin
            tokens     = FLAG_SENTINEL | {8'h00, b};
            need_token = 1'b1;
            is_token   = 1'b0;
          end
        end
        if (is_token) begin
          if (tokens[0]) begin
            if (room() == '0) begin
              err = ST_OVERFLOW;
            end else begin
              emit_byte(b);
              n++;
            end
          end else begin
            match_lo      = b;
            need_match_hi = 1'b1;
          end
        end
      end
    end
    if (last) begin
      st = err;
      if (st == ST_OK) begin
        if (need_token) st = ST_TRUNC;
        else if (produced != target_len) st = ST_MISMATCH;
      end
      push_beat(KIND_STAT, '0, st, produced);
      n++;
      clear_stream();
    end
    if (n > 0) begin
      tail      = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      target_len = '0;
      decoded_q.delete();
    end else begin
      if (cfg_we) target_len = cfg_wdata;
      if (in_w.valid && in_w.ready) decode_byte(in_w.in_byte, in_w.in_last);
      if (out_w.valid && out_w.ready) begin
        got = {out_w.out_kind, out_w.out_byte, out_w.end_status, out_w.out_count,
               out_w.out_last};
        if (decoded_q.size() == 0) begin
          bad++;
          $display("%0t: unexpected beat kind %0d byte %02h status %0d count %0d last %0d",
                   $time, got.kind, got.data, got.status, got.count, got.last);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            bad++;
            $display("%0t: expected kind %0d byte %02h status %0d count %0d last %0d",
                     $time, want.kind, want.data, want.status, want.count, want.last);
            $display("%0t:   actual kind %0d byte %02h status %0d count %0d last %0d",
                     $time, got.kind, got.data, got.status, got.count, got.last);
          end
        end
      end
    end
    mismatch_count <= bad;
    beats_owed     <= decoded_q.size();
  end

endmodule

`default_nettype wire

// File: verif/lzss_stream_decoder_test.sv
// stimulus and verdict for the lzss stream decoder, results checked by the checker module
`default_nettype none

module lzss_stream_decoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  localparam int END_PLAIN = 0;
  localparam int END_FLAG  = 1;
  localparam int END_CUT   = 2;

  localparam int PHASE_ITEMS = 80;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  int unsigned mismatch_count;
  int unsigned beats_owed;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          items_sent = 0;

  logic [BYTE_W-1:0] stream_q[$];

  lzss_in_if  comp_if ();
  lzss_out_if plain_if ();

  lzss_stream_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (comp_if),
    .out_m    (plain_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lzss_stream_decoder_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_w          (comp_if),
    .out_w         (plain_if),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .beats_owed    (beats_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    plain_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      plain_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic drain();
    comp_if.valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
  endtask

  task automatic set_length(input logic [CNT_W-1:0] len);
    drain();
    repeat (24) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      comp_if.valid <= 1'b0;
      @(posedge clk);
    end
    comp_if.valid   <= 1'b1;
    comp_if.in_byte <= b;
    comp_if.in_last <= last;
    do @(posedge clk); while (!comp_if.ready);
  endtask

  task automatic send_stream(input logic [CNT_W-1:0] len, input int pause_at);
    set_length(len);
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == pause_at) drain();
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    items_sent += stream_q.size();
  endtask

  task automatic build_stream(input int n_tok, input int match_pct, input bit long_runs,
                              input int end_mode, output int produced);
    logic [BYTE_W-1:0] flag;
    logic [WIN_AW-1:0] pos;
    logic [3:0]        code;
    int                back_pos;
    int                t;
    int                k;
    produced = 0;
    flag     = '0;
    stream_q.delete();
    if (end_mode == END_FLAG) n_tok = ((n_tok + 7) / 8) * 8;
    for (t = 0; t < n_tok; t++) begin
      if (t % 8 == 0) begin
        for (k = 0; k < 8; k++) flag[k] = ($urandom_range(0, 99) >= match_pct);
        if (end_mode == END_CUT && (n_tok - 1) / 8 == t / 8) flag[(n_tok - 1) % 8] = 1'b0;
        stream_q.push_back(flag);
      end
      if (flag[t % 8]) begin
        stream_q.push_back(BYTE_W'($urandom));
        produced++;
      end else begin
        code = long_runs ? 4'hf : 4'($urandom);
        case ($urandom_range(0, 3))
          0: pos = WIN_AW'($urandom);
          1: pos = $urandom_range(0, 1) ? {WIN_AW{1'b1}} : '0;
          default: begin
            back_pos = produced - int'($urandom_range(1, 24));
            pos      = back_pos[WIN_AW-1:0];
          end
        endcase
        stream_q.push_back(pos[7:0]);
        if (!(end_mode == END_CUT && t == n_tok - 1)) begin
          stream_q.push_back({code, pos[11:8]});
          produced += int'(code) + MIN_MATCH;
        end
      end
    end
    if (end_mode == END_FLAG) stream_q.push_back(BYTE_W'($urandom));
  endtask

  task automatic random_stream();
    int               produced;
    int               pick;
    int               mode;
    logic [CNT_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      stream_q.delete();
      repeat ($urandom_range(1, 12)) stream_q.push_back(BYTE_W'($urandom));
      produced = $urandom_range(0, 40);
    end else begin
      mode = (pick < 75) ? END_PLAIN : ((pick < 88) ? END_FLAG : END_CUT);
      build_stream($urandom_range(1, 20), $urandom_range(10, 90), 1'b0, mode, produced);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) len = CNT_W'(produced);
    else if (pick < 80) len = (produced > 6) ? CNT_W'(produced - int'($urandom_range(1, 6))) : '0;
    else if (pick < 90) len = CNT_W'(produced + int'($urandom_range(1, 6)));
    else if (pick < 95) len = '0;
    else len = '1;
    send_stream(len, ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1);
  endtask

  initial begin
    int produced;
    comp_if.valid   = 1'b0;
    comp_if.in_byte = '0;
    comp_if.in_last = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    stream_q = '{8'hfe, 8'h00, 8'h00, 8'hff};
    send_stream(24'd4, -1);
    stream_q = '{8'h01, 8'h00, 8'hff, 8'hff, 8'h00, 8'hf0, 8'h00};
    send_stream(24'hffffff, 4);
    stream_q = '{8'hff};
    send_stream(24'd0, -1);
    stream_q = '{8'h00, 8'h10, 8'h00, 8'h00, 8'h10, 8'h55, 8'haa, 8'h00};
    send_stream(24'd3, -1);
    stream_q = '{8'h03, 8'h41, 8'h42, 8'h43};
    send_stream(24'd1, -1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) random_stream();
      if (phase == 0) begin
        build_stream(40, 97, 1'b1, END_PLAIN, produced);
        send_stream(CNT_W'(produced), -1);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
